/* rtl/mnp_pkg.sv */
package mnp_pkg;

   localparam int unsigned PENDING_DEPTH = 64;
   localparam int unsigned CHANNELS      = 16;

   localparam int unsigned PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   localparam logic [2:0] ST_STORED    = 3'd0;
   localparam logic [2:0] ST_RESOLVED  = 3'd1;
   localparam logic [2:0] ST_SPURIOUS  = 3'd2;
   localparam logic [2:0] ST_IGNORED   = 3'd3;
   localparam logic [2:0] ST_UNTRACKED = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  channel;
      logic [6:0]  note_number;
      logic [6:0]  velocity;
      logic [31:0] event_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] note_index;
      logic [31:0] duration;
      logic [6:0]  note_velocity;
      logic [6:0]  stuck_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] note_index;
      logic [3:0]  channel;
      logic [6:0]  note_number;
      logic [31:0] start_time;
   } entry_type;

endpackage

/* rtl/mnp_req_if.sv */
interface mnp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  channel;
   logic [6:0]  note_number;
   logic [6:0]  velocity;
   logic [31:0] event_time;

   modport source (output valid, opcode, channel, note_number, velocity, event_time,
                   input ready);
   modport sink (input valid, opcode, channel, note_number, velocity, event_time,
                 output ready);
endinterface

/* rtl/mnp_rsp_if.sv */
interface mnp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] note_index;
   logic [31:0] duration;
   logic [6:0]  note_velocity;
   logic [6:0]  stuck_count;

   modport source (output valid, status, note_index, duration, note_velocity, stuck_count,
                   input ready);
   modport sink (input valid, status, note_index, duration, note_velocity, stuck_count,
                 output ready);
endinterface

/* rtl/mnp_engine.sv */
module mnp_engine
   import mnp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    sustained_mode,
   input  logic    start,
   input  req_type request,
   output logic    idle,
   output logic    done,
   output rsp_type result,
   input  logic    take
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      next_index_ff, next_index_in;
   req_type          key_ff, key_in;
   rsp_type          res_ff, res_in;
   entry_type        rdata_ff;

   entry_type        mem [PENDING_DEPTH];

   logic [PTR_W-1:0] rd_addr;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   entry_type        wr_data;

   logic [CNT_W-1:0] ptr_ext;
   logic             chan_ok;
   logic             has_room;
   logic             hit;
   logic             last_scan;
   logic             last_shift;
   logic [31:0]      span;

   assign ptr_ext    = CNT_W'(ptr_ff);
   assign chan_ok    = 32'(request.channel) < CHANNELS;
   assign has_room   = 32'(count_ff) < PENDING_DEPTH;
   assign hit        = (rdata_ff.channel == key_ff.channel) &&
                       (rdata_ff.note_number == key_ff.note_number);
   assign last_scan  = (ptr_ext + CNT_W'(1)) == count_ff;
   assign last_shift = (ptr_ext + CNT_W'(2)) == count_ff;
   assign span       = (key_ff.event_time >= rdata_ff.start_time) ?
                       (key_ff.event_time - rdata_ff.start_time) : 32'd0;

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign result = res_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      next_index_in = next_index_ff;
      key_in        = key_ff;
      res_in        = res_ff;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[PTR_W-1:0];
      wr_data       = '{note_index: next_index_ff, channel: request.channel,
                        note_number: request.note_number,
                        start_time: request.event_time};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in = '0;
               key_in = request;
               unique case (request.opcode)
                  OP_NOTE_ON: begin
                     res_in.note_index    = next_index_ff;
                     res_in.note_velocity = request.velocity;
                     res_in.status        = ST_STORED;
                     next_index_in        = next_index_ff + 16'd1;
                     if (sustained_mode) begin
                        if (has_room && chan_ok) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end else begin
                           res_in.status = ST_UNTRACKED;
                        end
                     end
                     state_in = S_DONE;
                  end
                  OP_NOTE_OFF: begin
                     if (!sustained_mode) begin
                        res_in.status = ST_IGNORED;
                        state_in      = S_DONE;
                     end else if (count_ff == '0) begin
                        res_in.status = ST_SPURIOUS;
                        state_in      = S_DONE;
                     end else begin
                        ptr_in   = '0;
                        rd_addr  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     res_in.status      = ST_CLEARED;
                     res_in.stuck_count = (32'(count_ff) > 127) ? 7'd127 : 7'(count_ff);
                     count_in           = '0;
                     state_in           = S_DONE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_in.status     = ST_RESOLVED;
               res_in.note_index = rdata_ff.note_index;
               res_in.duration   = span;
               if (last_scan) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end else begin
                  rd_addr  = PTR_W'(ptr_ext + CNT_W'(1));
                  state_in = S_SHIFT;
               end
            end else if (last_scan) begin
               res_in.status = ST_SPURIOUS;
               state_in      = S_DONE;
            end else begin
               ptr_in  = PTR_W'(ptr_ext + CNT_W'(1));
               rd_addr = PTR_W'(ptr_ext + CNT_W'(1));
            end
         end
         S_SHIFT: begin
            // rdata holds the entry above ptr; move it down one place.
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rdata_ff;
            if (last_shift) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               ptr_in  = PTR_W'(ptr_ext + CNT_W'(1));
               rd_addr = PTR_W'(ptr_ext + CNT_W'(2));
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_index_ff <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         next_index_ff <= next_index_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

endmodule

/* rtl/midi_note_on_off_pairing_top.sv */
// Channel   Dir  Handshake     Carries
// req_bus   in   valid/ready   opcode, channel, note_number, velocity, event_time
// rsp_bus   out  valid/ready   status, note_index, duration, note_velocity, stuck_count
// csr_*     in   write enable  sustained_mode
//
// A note-on, a clear, or a note-off in percussive mode or against an empty table goes
// from idle straight to the done state, and the block is ready again once its result
// moves to the output register. A sustained note-off with n pending notes scans and then
// shifts the table through the single memory read port, one entry per cycle, n entries
// in all, before its response is loaded. Reset is synchronous and empties the table at
// once, since the fill count alone marks live entries.
// A stalled response holds in the output register while the next request is taken.
module midi_note_on_off_pairing_top
   import mnp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mnp_req_if.sink   req_bus,
   mnp_rsp_if.source rsp_bus,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   // Mode register: 1 tracks durations, 0 treats every note as percussive.
   logic sustained_mode_ff, sustained_mode_in;

   // Output register decouples the engine from a stalled consumer.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   req_type request;
   rsp_type eng_result;
   logic    eng_idle;
   logic    eng_done;
   logic    eng_take;
   logic    start;

   assign request = '{opcode: req_bus.opcode, channel: req_bus.channel,
                      note_number: req_bus.note_number, velocity: req_bus.velocity,
                      event_time: req_bus.event_time};

   // The engine takes a request only while its sequencer is idle.
   assign req_bus.ready = eng_idle;
   assign start         = req_bus.valid && eng_idle;

   // A finished result moves out when the output register is empty or draining.
   assign eng_take = eng_done && (!rsp_valid_ff || rsp_bus.ready);

   assign sustained_mode_in = csr_we ? csr_wdata : sustained_mode_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   mnp_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .sustained_mode (sustained_mode_ff),
      .start          (start),
      .request        (request),
      .idle           (eng_idle),
      .done           (eng_done),
      .result         (eng_result),
      .take           (eng_take)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sustained_mode_ff <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         sustained_mode_ff <= sustained_mode_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_data_ff.status;
   assign rsp_bus.note_index    = rsp_data_ff.note_index;
   assign rsp_bus.duration      = rsp_data_ff.duration;
   assign rsp_bus.note_velocity = rsp_data_ff.note_velocity;
   assign rsp_bus.stuck_count   = rsp_data_ff.stuck_count;

endmodule
